@@ rtl/rce_pkg.sv @@
// Package for the stopwatch core: action codes, run modes and the time and lap records.
// No dependencies; the core, rce_elapsed and rce_ctrl use it.
`default_nettype none

package rce_pkg;

  // Number of time fields, hundredths up to years.
  localparam int unsigned NFIELDS = 7;

  // Action codes carried by each input item. Codes above reset act as read.
  localparam logic [2:0] ACT_READ   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_STOP   = 3'd2;
  localparam logic [2:0] ACT_RESUME = 3'd3;
  localparam logic [2:0] ACT_RESET  = 3'd4;

  // Borrow amounts for hundredths, seconds, minutes, hours, days and months.
  localparam logic [6:0] BORROW_MOD [NFIELDS-1] = '{7'd100, 7'd60, 7'd60, 7'd24, 7'd30, 7'd12};

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_RUNNING  = 2'd1,
    MODE_STOPPED  = 2'd2
  } mode_t;

  // A sampled clock time with the subsecond already in hundredths.
  typedef struct packed {
    logic [6:0] hund;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } time_t;

  // An elapsed value; the year difference may be negative.
  typedef struct packed {
    logic [6:0]        hund;
    logic [5:0]        sec;
    logic [5:0]        min;
    logic [4:0]        hour;
    logic [4:0]        day;
    logic [3:0]        month;
    logic signed [7:0] year;
  } lap_t;

  // Control handed from the pipeline to the state keeper.
  typedef struct packed {
    logic       fire;
    logic [2:0] action;
  } step_t;

endpackage

`default_nettype wire

@@ rtl/rce_in_if.sv @@
// Input channel of the stopwatch core: valid/ready handshake with action and clock time.
// No dependencies.
`default_nettype none

interface rce_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] now_subsecond;
  logic [5:0] now_second;
  logic [5:0] now_minute;
  logic [4:0] now_hour;
  logic [4:0] now_day;
  logic [3:0] now_month;
  logic [6:0] now_year;

  modport source (
    output valid, action, now_subsecond, now_second, now_minute, now_hour,
           now_day, now_month, now_year,
    input  ready
  );

  modport sink (
    input  valid, action, now_subsecond, now_second, now_minute, now_hour,
           now_day, now_month, now_year,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/rce_out_if.sv @@
// Result channel of the stopwatch core: valid/ready handshake with lap fields and run mode.
// No dependencies.
`default_nettype none

interface rce_out_if;
  logic              valid;
  logic              ready;
  logic [6:0]        lap_hundredth;
  logic [5:0]        lap_second;
  logic [5:0]        lap_minute;
  logic [4:0]        lap_hour;
  logic [4:0]        lap_day;
  logic [3:0]        lap_month;
  logic signed [7:0] lap_year;
  logic [1:0]        run_mode;

  modport source (
    output valid, lap_hundredth, lap_second, lap_minute, lap_hour, lap_day,
           lap_month, lap_year, run_mode,
    input  ready
  );

  modport sink (
    input  valid, lap_hundredth, lap_second, lap_minute, lap_hour, lap_day,
           lap_month, lap_year, run_mode,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/rtc_chronograph_elapsed_core.sv @@
// Stopwatch core: one result per item, through an input register and then a result
// register. Throughput is one item per cycle while out_ch.ready does not hold the result.
// Synchronous active-low reset empties both stages, sets the mode inactive and clears
// the start time and held lap. Depends on rce_pkg, rce_in_if, rce_out_if, rce_elapsed
// and rce_ctrl.
`default_nettype none

module rtc_chronograph_elapsed_core (
  input  wire  clk,
  input  wire  rst_n,
  rce_in_if.sink    in_ch,
  rce_out_if.source out_ch
);

  // Subsecond down-count to hundredths: floor((255 - sub) * 100 / 255) via the
  // exact identity x / 255 = (x + (x >> 8) + 1) >> 8 for these values.
  function automatic logic [6:0] sub_to_hund(input logic [7:0] sub);
    logic [7:0]  inv;
    logic [14:0] x;
    logic [15:0] s;
    inv = 8'hFF - sub;
    x   = 15'(inv) * 15'd100;
    s   = 16'(x) + 16'(x[14:8]) + 16'd1;
    return s[14:8];
  endfunction

  logic           s1_valid_r;
  logic [2:0]     s1_action_r;
  logic [7:0]     s1_sub_r;
  logic [5:0]     s1_sec_r;
  logic [5:0]     s1_min_r;
  logic [4:0]     s1_hour_r;
  logic [4:0]     s1_day_r;
  logic [3:0]     s1_month_r;
  logic [6:0]     s1_year_r;

  logic           out_valid_r;
  rce_pkg::lap_t  out_lap_r;
  rce_pkg::mode_t out_mode_r;

  logic           fire;
  rce_pkg::step_t step;
  rce_pkg::time_t now;
  rce_pkg::time_t start_time;
  rce_pkg::lap_t  elap;
  rce_pkg::lap_t  res_lap;
  rce_pkg::mode_t res_mode;

  // The input stage moves on whenever the result register is free or being taken.
  assign fire        = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_action_r <= in_ch.action;
      s1_sub_r    <= in_ch.now_subsecond;
      s1_sec_r    <= in_ch.now_second;
      s1_min_r    <= in_ch.now_minute;
      s1_hour_r   <= in_ch.now_hour;
      s1_day_r    <= in_ch.now_day;
      s1_month_r  <= in_ch.now_month;
      s1_year_r   <= in_ch.now_year;
    end
  end

  // Current time record for the item in the input stage.
  always_comb begin
    now.hund  = sub_to_hund(s1_sub_r);
    now.sec   = s1_sec_r;
    now.min   = s1_min_r;
    now.hour  = s1_hour_r;
    now.day   = s1_day_r;
    now.month = s1_month_r;
    now.year  = s1_year_r;
  end

  assign step.fire   = fire;
  assign step.action = s1_action_r;

  rce_elapsed u_elapsed (
    .now   (now),
    .start (start_time),
    .lap   (elap)
  );

  rce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .now        (now),
    .elap       (elap),
    .start_time (start_time),
    .res_lap    (res_lap),
    .res_mode   (res_mode)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_lap_r  <= res_lap;
      out_mode_r <= res_mode;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.lap_hundredth = out_lap_r.hund;
  assign out_ch.lap_second    = out_lap_r.sec;
  assign out_ch.lap_minute    = out_lap_r.min;
  assign out_ch.lap_hour      = out_lap_r.hour;
  assign out_ch.lap_day       = out_lap_r.day;
  assign out_ch.lap_month     = out_lap_r.month;
  assign out_ch.lap_year      = out_lap_r.year;
  assign out_ch.run_mode      = out_mode_r;

endmodule

`default_nettype wire

@@ rtl/rce_elapsed.sv @@
// Field-by-field subtraction of the start time from the current time with single borrows.
// Depends on rce_pkg for the time and lap records and the borrow amounts.
`default_nettype none

module rce_elapsed (
  input  wire rce_pkg::time_t now,
  input  wire rce_pkg::time_t start,
  output rce_pkg::lap_t       lap
);

  logic signed [8:0] raw [rce_pkg::NFIELDS];
  logic signed [8:0] fix [rce_pkg::NFIELDS];

  // Plain differences, each zero-extended into a signed nine-bit word.
  always_comb begin
    raw[0] = $signed({2'b00, now.hund})  - $signed({2'b00, start.hund});
    raw[1] = $signed({3'b000, now.sec})  - $signed({3'b000, start.sec});
    raw[2] = $signed({3'b000, now.min})  - $signed({3'b000, start.min});
    raw[3] = $signed({4'b0000, now.hour}) - $signed({4'b0000, start.hour});
    raw[4] = $signed({4'b0000, now.day})  - $signed({4'b0000, start.day});
    raw[5] = $signed({5'b00000, now.month}) - $signed({5'b00000, start.month});
    raw[6] = $signed({2'b00, now.year})  - $signed({2'b00, start.year});
  end

  // Borrow chain from hundredths up to months; the year only takes the borrow.
  always_comb begin
    logic              bin;
    logic signed [8:0] adj;
    bin = 1'b0;
    for (int i = 0; i < rce_pkg::NFIELDS; i++) begin
      adj = raw[i] - $signed({8'b0, bin});
      if (i < rce_pkg::NFIELDS - 1 && adj < 0) begin
        fix[i] = adj + $signed({2'b00, rce_pkg::BORROW_MOD[i]});
        bin    = 1'b1;
      end else begin
        fix[i] = adj;
        bin    = 1'b0;
      end
    end
  end

  // Each result field keeps only its own width.
  assign lap.hund  = fix[0][6:0];
  assign lap.sec   = fix[1][5:0];
  assign lap.min   = fix[2][5:0];
  assign lap.hour  = fix[3][4:0];
  assign lap.day   = fix[4][4:0];
  assign lap.month = fix[5][3:0];
  assign lap.year  = fix[6][7:0];

endmodule

`default_nettype wire

@@ rtl/rce_ctrl.sv @@
// Run-mode, start-time and held-lap registers of the stopwatch, and the result selection.
// Depends on rce_pkg for action codes, modes and the time and lap records.
`default_nettype none

module rce_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire rce_pkg::step_t step,
  input  wire rce_pkg::time_t now,
  input  wire rce_pkg::lap_t  elap,
  output rce_pkg::time_t      start_time,
  output rce_pkg::lap_t       res_lap,
  output rce_pkg::mode_t      res_mode
);

  rce_pkg::mode_t mode_r, mode_nxt;
  rce_pkg::time_t start_r, start_nxt;
  rce_pkg::lap_t  held_r, held_nxt;

  // State registers move only when an item leaves the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= rce_pkg::MODE_INACTIVE;
      start_r <= '0;
      held_r  <= '0;
    end else if (step.fire) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      held_r  <= held_nxt;
    end
  end

  // Next state from the action, then the result for the state after it.
  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    held_nxt  = held_r;
    case (step.action)
      rce_pkg::ACT_START: begin
        start_nxt = now;
        mode_nxt  = rce_pkg::MODE_RUNNING;
      end
      rce_pkg::ACT_STOP: begin
        if (mode_r == rce_pkg::MODE_RUNNING) begin
          held_nxt = elap;
        end else if (mode_r == rce_pkg::MODE_INACTIVE) begin
          held_nxt = '0;
        end
        mode_nxt = rce_pkg::MODE_STOPPED;
      end
      rce_pkg::ACT_RESUME: begin
        mode_nxt = rce_pkg::MODE_RUNNING;
      end
      rce_pkg::ACT_RESET: begin
        start_nxt = '0;
        held_nxt  = '0;
        mode_nxt  = rce_pkg::MODE_INACTIVE;
      end
      default: begin
      end
    endcase

    // A fresh start measures from this same time, so its lap is zero.
    res_lap = '0;
    case (mode_nxt)
      rce_pkg::MODE_RUNNING: begin
        if (step.action != rce_pkg::ACT_START) begin
          res_lap = elap;
        end
      end
      rce_pkg::MODE_STOPPED: begin
        res_lap = held_nxt;
      end
      default: begin
        res_lap = '0;
      end
    endcase
  end

  assign res_mode   = mode_nxt;
  assign start_time = start_r;

`ifndef NO_ASSERTIONS
  // A start captures the current time as the new start time.
  a_start_capture: assert property (@(posedge clk) disable iff (!rst_n)
    step.fire && step.action == rce_pkg::ACT_START |=> start_r == $past(now))
    else $error("start time not captured on start");

  // A reset action clears all stored state.
  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step.fire && step.action == rce_pkg::ACT_RESET
    |=> mode_r == rce_pkg::MODE_INACTIVE && start_r == '0 && held_r == '0)
    else $error("reset action left state behind");

  // A stop while already stopped keeps the held lap.
  a_stop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step.fire && step.action == rce_pkg::ACT_STOP && mode_r == rce_pkg::MODE_STOPPED
    |=> held_r == $past(held_r))
    else $error("held lap changed on repeated stop");

  // An inactive result reports a zero lap.
  a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    step.fire && mode_nxt == rce_pkg::MODE_INACTIVE |-> res_lap == '0)
    else $error("inactive result carries a nonzero lap");
`endif

endmodule

`default_nettype wire
